// ===== rtl/tdr_pkg.sv =====
package tdr_pkg;

   localparam int TILE_SIZE       = 16;
   localparam int DEF_MAX_WIDTH   = 4096;
   localparam int DEF_MAX_HEIGHT  = 4096;

   // register sizes fixed by the register map
   localparam int TILES_W = 9;
   localparam int BAND_W  = 8;
   localparam int PIX_W   = 8;

   // item kinds on the request side
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // csr register indexes
   localparam logic CSR_WIDTH_TILES  = 1'b0;
   localparam logic CSR_HEIGHT_TILES = 1'b1;

   // in-tile row/column interleave: 0..7 woven with 8..15
   localparam logic [3:0] IDX_MAP [0:15] = '{
      4'd0, 4'd8, 4'd1, 4'd9, 4'd2, 4'd10, 4'd3, 4'd11,
      4'd4, 4'd12, 4'd5, 4'd13, 4'd6, 4'd14, 4'd7, 4'd15
   };

   // per-item outcome from the sequencer
   typedef struct packed {
      logic emit;
      logic row_end;
      logic frame_end;
   } step_flags_type;

endpackage

// ===== rtl/tdr_band_store.sv =====
module tdr_band_store
   import tdr_pkg::*;
#(
   parameter int ADDR_W = 17
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [PIX_W-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [PIX_W-1:0]  rd_data
);

   logic [PIX_W-1:0] mem [0:(2**ADDR_W)-1];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tdr_seq.sv =====
module tdr_seq
   import tdr_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int COL_W     = $clog2(MAX_WIDTH),
   parameter int ADDR_W    = 1 + 4 + COL_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              kind,
   input  logic [COL_W-1:0]  last_col,
   input  logic [BAND_W-1:0] last_band,
   output step_flags_type    flags,
   output logic [ADDR_W-1:0] rd_addr,
   output logic [ADDR_W-1:0] wr_addr
);

   logic [COL_W-1:0]  in_col_ff,   in_col_in;
   logic [3:0]        in_row_ff,   in_row_in;
   logic [BAND_W-1:0] in_band_ff,  in_band_in;
   logic              wbank_ff,    wbank_in;
   logic [COL_W-1:0]  out_col_ff,  out_col_in;
   logic [3:0]        out_row_ff,  out_row_in;
   logic [BAND_W-1:0] out_band_ff, out_band_in;
   logic              pend_ff,     pend_in;
   logic [COL_W-1:0]  src_col;

   // column inside the tile replaced by its interleaved source
   assign src_col = (out_col_ff & ~COL_W'(15)) | COL_W'(IDX_MAP[out_col_ff[3:0]]);

   assign rd_addr = {~wbank_ff, IDX_MAP[out_row_ff], src_col};
   assign wr_addr = {wbank_ff, in_row_ff, in_col_ff};

   always_comb begin
      flags.emit      = pend_ff;
      flags.row_end   = (out_col_ff >= last_col);
      flags.frame_end = flags.row_end && (out_row_ff == 4'hF) && (out_band_ff >= last_band);

      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_band_in  = in_band_ff;
      wbank_in    = wbank_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_band_in = out_band_ff;
      pend_in     = pend_ff;

      // read side first
      if (step && pend_ff) begin
         if (flags.row_end) begin
            out_col_in = '0;
            if (out_row_ff == 4'hF) begin
               out_row_in = '0;
               pend_in    = 1'b0;
            end else begin
               out_row_in = out_row_ff + 4'd1;
            end
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end

      // load side, a finished band takes over the read side
      if (step && (kind == KIND_PIXEL)) begin
         if (in_col_ff >= last_col) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 4'd1;
            if (in_row_ff == 4'hF) begin
               wbank_in    = ~wbank_ff;
               pend_in     = 1'b1;
               out_col_in  = '0;
               out_row_in  = '0;
               out_band_in = in_band_ff;
               in_band_in  = (in_band_ff >= last_band) ? '0 : in_band_ff + BAND_W'(1);
            end
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_band_ff  <= '0;
         wbank_ff    <= 1'b0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_band_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_band_ff  <= in_band_in;
         wbank_ff    <= wbank_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_band_ff <= out_band_in;
         pend_ff     <= pend_in;
      end
   end

endmodule

// ===== rtl/jp4_tile_deblock_reorder_core.sv =====
// Tile deinterleaver with a ping-pong band store. Grayscale pixels enter in raster order
// and each 16-row band is written into one half of the store; while a band loads, the
// previous band is read from the other half and sent out in raster order, with every
// 16x16 tile's rows and columns taken in the order 0,8,1,9,...,7,15. Every item
// yields one result once a band is pending; drain items (tuser high) push out the last
// band without loading. The block takes one item per clock while the result side does not
// stall, and a result is offered once its item has passed the input register and then the
// store's registered read port, which is also the result register. The store has one
// write and one read port, each used at most once per item. The store is not
// cleared after reset; entries are only read after the band that owns them was loaded.
// width_tiles and height_tiles are clamped to 1 and to MAX_WIDTH/16 (MAX_HEIGHT/16), at
// most 256, and should be written while idle.
module jp4_tile_deblock_reorder_core
   import tdr_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] pixel_in
   input  logic               req_tuser,   // [0] kind
   // result channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // [7:0] pixel_out
   output logic               rsp_tlast,   // row_end
   output logic               rsp_tuser,   // [0] frame_end
   // csr write port
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [TILES_W-1:0] csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ADDR_W = 1 + 4 + COL_W;
   // tile count limits
   localparam int WT_RAW = MAX_WIDTH / TILE_SIZE;
   localparam int HT_RAW = MAX_HEIGHT / TILE_SIZE;
   localparam int WT_LIM = (WT_RAW > 256) ? 256 : ((WT_RAW < 1) ? 1 : WT_RAW);
   localparam int HT_LIM = (HT_RAW > 256) ? 256 : ((HT_RAW < 1) ? 1 : HT_RAW);

   // csr registers and the limits derived from them
   logic [TILES_W-1:0] width_tiles_ff,  width_tiles_in;
   logic [TILES_W-1:0] height_tiles_ff, height_tiles_in;
   logic [COL_W-1:0]   last_col_ff,     last_col_in;
   logic [BAND_W-1:0]  last_band_ff,    last_band_in;
   logic [TILES_W-1:0] wt_clamp, ht_clamp, wt_m1, ht_m1;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic               in_kind_ff,  in_kind_in;
   logic [PIX_W-1:0]   in_pix_ff,   in_pix_in;

   // result register (pixel lives in the store's read register)
   logic               rsp_valid_ff, rsp_valid_in;
   logic               row_end_ff,   row_end_in;
   logic               frame_end_ff, frame_end_in;

   logic               req_accept, rsp_free, go, rd_en, wr_en;
   step_flags_type     flags;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic [PIX_W-1:0]   rd_data;

   // csr writes
   always_comb begin
      width_tiles_in  = width_tiles_ff;
      height_tiles_in = height_tiles_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WIDTH_TILES:  width_tiles_in  = csr_wdata;
            CSR_HEIGHT_TILES: height_tiles_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp tile counts, then store last column and last band index
   // (taken from the next register values so a write counts from the following item)
   always_comb begin
      wt_clamp = width_tiles_in;
      if (width_tiles_in == '0) begin
         wt_clamp = TILES_W'(1);
      end else if (width_tiles_in > TILES_W'(WT_LIM)) begin
         wt_clamp = TILES_W'(WT_LIM);
      end
      ht_clamp = height_tiles_in;
      if (height_tiles_in == '0) begin
         ht_clamp = TILES_W'(1);
      end else if (height_tiles_in > TILES_W'(HT_LIM)) begin
         ht_clamp = TILES_W'(HT_LIM);
      end
      wt_m1        = wt_clamp - TILES_W'(1);
      ht_m1        = ht_clamp - TILES_W'(1);
      last_col_in  = COL_W'({wt_m1[BAND_W-1:0], 4'hF});
      last_band_in = ht_m1[BAND_W-1:0];
   end

   // handshake: the input register moves on whenever the result slot is free,
   // nothing is taken while in reset
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign go         = in_valid_ff && rsp_free;
   assign req_tready = !reset && (!in_valid_ff || go);
   assign rd_en      = go && flags.emit;
   assign wr_en      = go && (in_kind_ff == KIND_PIXEL);

   always_comb begin
      in_valid_in = in_valid_ff;
      in_kind_in  = in_kind_ff;
      in_pix_in   = in_pix_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_kind_in  = req_tuser;
         in_pix_in   = req_tdata;
      end else if (go) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      row_end_in   = row_end_ff;
      frame_end_in = frame_end_ff;
      if (rsp_free) begin
         rsp_valid_in = rd_en;
      end
      if (rd_en) begin
         row_end_in   = flags.row_end;
         frame_end_in = flags.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_tiles_ff  <= TILES_W'(1);
         height_tiles_ff <= TILES_W'(1);
         last_col_ff     <= COL_W'(TILE_SIZE - 1);
         last_band_ff    <= '0;
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         width_tiles_ff  <= width_tiles_in;
         height_tiles_ff <= height_tiles_in;
         last_col_ff     <= last_col_in;
         last_band_ff    <= last_band_in;
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_kind_ff   <= in_kind_in;
      in_pix_ff    <= in_pix_in;
      row_end_ff   <= row_end_in;
      frame_end_ff <= frame_end_in;
   end

   tdr_seq #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W),
      .ADDR_W    (ADDR_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .step      (go),
      .kind      (in_kind_ff),
      .last_col  (last_col_ff),
      .last_band (last_band_ff),
      .flags     (flags),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr)
   );

   tdr_band_store #(
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_pix_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rd_data;
   assign rsp_tlast  = row_end_ff;
   assign rsp_tuser  = frame_end_ff;

endmodule

// ===== rtl/tdr_checker.sv =====
module tdr_checker
   import tdr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // frame end only on the last pixel of a row
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without row end");

   // a new result is offered only after its item has passed the input register and the store's read register
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without an accepted item");

   // out of reset and with no result waiting the input side is open
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !reset && !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result slot");

endmodule

bind jp4_tile_deblock_reorder_core tdr_checker u_tdr_checker (.*);

// ===== sim/tb_jp4_tile_deblock_reorder_core.sv =====
`timescale 1ns / 100ps

module tb_jp4_tile_deblock_reorder_core
   import tdr_pkg::*;
();

   // one bank holds 16 rows of the widest frame; two banks in the store
   localparam int STORE_COLS    = DEF_MAX_WIDTH;
   localparam int STORE_DEPTH   = 2 * TILE_SIZE * STORE_COLS;
   localparam int ITEM_TARGET   = 1870;
   localparam int LONG_HOLD     = 400;
   localparam int STALL_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 4;

   // one emitted sample as the block should produce it
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             row_end;
      logic             frame_end;
   } emit_sample_type;

   // shadow of the band store and the load/emit counters, plus the sample queue
   class tile_reorder_scoreboard;
      logic [PIX_W-1:0]   band_mem [STORE_DEPTH];
      logic [TILES_W-1:0] width_reg;
      logic [TILES_W-1:0] height_reg;
      int unsigned        load_col, load_row, emit_col, emit_row, emit_band;
      bit                 load_bank, emit_busy;
      emit_sample_type    expected_q[$];
      int unsigned        items_in, pixels_in, drains_in, reg_writes, bands_loaded;
      int unsigned        samples_seen, row_ends, frame_ends, errors;

      function new();
         width_reg  = 1;
         height_reg = 1;
      endfunction

      function void write_reg(logic idx, logic [TILES_W-1:0] value);
         if (idx == CSR_WIDTH_TILES)
            width_reg = value;
         else
            height_reg = value;
         reg_writes++;
      endfunction

      function int unsigned clamp_tiles(logic [TILES_W-1:0] raw, int unsigned max_tiles);
         int unsigned lim, t;
         lim = (max_tiles > 256) ? 256 : max_tiles;
         if (lim < 1) lim = 1;
         t = raw;
         if (t < 1) t = 1;
         if (t > lim) t = lim;
         return t;
      endfunction

      // 0..7 woven with 8..15: even slots count up low half, odd slots high half
      function logic [3:0] weave(logic [3:0] i);
         return {i[0], i[3:1]};
      endfunction

      function void load_item(logic kind, logic [PIX_W-1:0] pix);
         int unsigned cols, bands, mem_row, mem_col;
         emit_sample_type s;
         cols  = clamp_tiles(width_reg, DEF_MAX_WIDTH / TILE_SIZE) * TILE_SIZE;
         bands = clamp_tiles(height_reg, DEF_MAX_HEIGHT / TILE_SIZE);
         items_in++;
         // the pending band is read before this item's pixel is stored
         if (emit_busy) begin
            mem_row     = {~load_bank, weave(emit_row[3:0])};
            mem_col     = (emit_col & ~32'hF) | weave(emit_col[3:0]);
            s.pixel     = band_mem[mem_row * STORE_COLS + mem_col];
            s.row_end   = (emit_col + 1 >= cols);
            s.frame_end = s.row_end && emit_row == 15 && (emit_band + 1 >= bands);
            expected_q.push_back(s);
            if (s.row_end) begin
               emit_col = 0;
               if (emit_row == 15) begin
                  emit_row  = 0;
                  emit_busy = 1'b0;
               end else begin
                  emit_row++;
               end
            end else begin
               emit_col++;
            end
         end
         if (kind == KIND_PIXEL) begin
            pixels_in++;
            mem_row = {load_bank, load_row[3:0]};
            band_mem[mem_row * STORE_COLS + load_col] = pix;
            if (load_col + 1 >= cols) begin
               load_col = 0;
               if (load_row[3:0] == 4'hF) begin
                  // band complete: flip banks and start emitting it
                  load_bank = ~load_bank;
                  emit_busy = 1'b1;
                  emit_col  = 0;
                  emit_row  = 0;
                  emit_band = (load_row >> 4) & 8'hFF;
                  bands_loaded++;
                  load_row  = (load_row + 1 >= bands * TILE_SIZE) ? 0 : load_row + 1;
               end else begin
                  load_row++;
               end
            end else begin
               load_col++;
            end
         end else begin
            drains_in++;
         end
      endfunction

      function void report(string field, int unsigned want, int unsigned got);
         errors++;
         $error("%s: expected %0d, got %0d", field, want, got);
      endfunction

      function void compare_sample(logic [PIX_W-1:0] pix, logic row_end, logic frame_end);
         emit_sample_type s;
         if (expected_q.size() == 0) begin
            errors++;
            $error("result with no sample expected: pixel_out %0d", pix);
            return;
         end
         s = expected_q.pop_front();
         samples_seen++;
         if (s.row_end) row_ends++;
         if (s.frame_end) frame_ends++;
         if (pix !== s.pixel) report("pixel_out", s.pixel, pix);
         if (row_end !== s.row_end) report("row_end", s.row_end, row_end);
         if (frame_end !== s.frame_end) report("frame_end", s.frame_end, frame_end);
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;
   logic               req_tuser  = KIND_PIXEL;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;
   logic               rsp_tlast;
   logic               rsp_tuser;
   logic               csr_we     = 1'b0;
   logic               csr_index  = CSR_WIDTH_TILES;
   logic [TILES_W-1:0] csr_wdata  = '0;

   tile_reorder_scoreboard sb = new();

   // quiet: no idling on either side for the tail of the run
   bit          quiet        = 1'b0;
   int unsigned idle_cycles  = 0;

   always #4 clock = ~clock;

   jp4_tile_deblock_reorder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // offer one item, optionally after an idle burst; returns at the accepting edge
   task automatic send_item(input logic kind, input logic [7:0] pix);
      int unsigned gap;
      gap = 0;
      if (sb.items_in > ITEM_TARGET - 500)
         quiet = 1'b1;
      if (!quiet && $urandom_range(0, 6) == 0)
         gap = $urandom_range(1, 17);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= pix;
      // tready is stable mid-cycle, so the negedge tells whether the next edge accepts
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      sb.load_item(kind, pix);
   endtask

   // pixels with random content until n more bands are loaded, drains mixed in
   task automatic stream_bands(input int unsigned n, input int unsigned drain_pct);
      int unsigned goal;
      goal = sb.bands_loaded + n;
      while (sb.bands_loaded < goal) begin
         if ($urandom_range(0, 99) < drain_pct)
            send_item(KIND_DRAIN, 8'($urandom_range(0, 255)));
         send_item(KIND_PIXEL, 8'($urandom_range(0, 255)));
      end
   endtask

   // drain the pending band, then up to two drains that find nothing to emit
   task automatic flush_band();
      while (sb.emit_busy)
         send_item(KIND_DRAIN, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2))
         send_item(KIND_DRAIN, 8'($urandom_range(0, 255)));
   endtask

   // stop offering, wait for every sample, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [TILES_W-1:0] w, input logic [TILES_W-1:0] h);
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH_TILES;
      csr_wdata <= w;
      @(posedge clock);
      sb.write_reg(CSR_WIDTH_TILES, w);
      csr_index <= CSR_HEIGHT_TILES;
      csr_wdata <= h;
      @(posedge clock);
      sb.write_reg(CSR_HEIGHT_TILES, h);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned w, h;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // drains with nothing pending, then pixel extremes, walking ones, other bit patterns and a drain
      send_item(KIND_DRAIN, 8'hFF);
      send_item(KIND_DRAIN, 8'h00);
      send_item(KIND_PIXEL, 8'h00);
      send_item(KIND_PIXEL, 8'hFF);
      for (int k = 0; k < 8; k++)
         send_item(KIND_PIXEL, 8'h01 << k);
      send_item(KIND_PIXEL, 8'h55);
      send_item(KIND_PIXEL, 8'hAA);
      send_item(KIND_PIXEL, 8'h7F);
      send_item(KIND_PIXEL, 8'hFE);
      send_item(KIND_DRAIN, 8'hA5);
      // finish the one-tile frame at reset sizes and drain it
      stream_bands(1, 0);
      flush_band();

      // all-ones width clamps to the widest frame; load part of its first row
      settle();
      write_regs(9'h1FF, 9'h000);
      repeat (40) send_item(KIND_PIXEL, 8'($urandom_range(0, 255)));
      // narrow mid-row: the column counter wraps on the next pixel,
      // and an all-ones height keeps frame_end away from this band
      settle();
      write_regs(9'h000, 9'h1FF);
      stream_bands(1, 4);
      flush_band();

      // random frames; the height drop mid-frame wraps the row counter
      while (sb.items_in < ITEM_TARGET) begin
         if (sb.items_in > ITEM_TARGET - 600) begin
            w = 1;
            h = $urandom_range(0, 1);
         end else begin
            w = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(0, 1);
            h = (w == 2) ? $urandom_range(0, 1) : $urandom_range(0, 2);
         end
         settle();
         write_regs(TILES_W'(w), TILES_W'(h));
         stream_bands((h == 0) ? 1 : h, $urandom_range(0, 8));
         flush_band();
      end

      settle();
      $display("covered %0d items (%0d pixels, %0d drains), %0d bands, %0d register writes",
               sb.items_in, sb.pixels_in, sb.drains_in, sb.bands_loaded, sb.reg_writes);
      $display("checked %0d samples with %0d row ends and %0d frame ends, %0d mismatches",
               sb.samples_seen, sb.row_ends, sb.frame_ends, sb.errors);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: random stalls, one long hold once a band is pending, always ready at the tail
   initial begin : rsp_side
      logic        level;
      int unsigned span;
      bit          hold_done;
      hold_done = 1'b0;
      forever begin
         if (quiet) begin
            level = 1'b1;
            span  = 1;
         end else if (!hold_done && sb.emit_busy) begin
            level     = 1'b0;
            span      = LONG_HOLD;
            hold_done = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            level = 1'b0;
            span  = $urandom_range(1, 17);
         end else begin
            level = 1'b1;
            span  = $urandom_range(1, 40);
         end
         rsp_tready <= level;
         repeat (span) @(posedge clock);
      end
   end

   // result check and watchdog, sampled mid-cycle where all signals are settled
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.compare_sample(rsp_tdata, rsp_tlast, rsp_tuser);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
rtl/tdr_pkg.sv
rtl/tdr_band_store.sv
rtl/tdr_seq.sv
rtl/jp4_tile_deblock_reorder_core.sv
rtl/tdr_checker.sv
sim/tb_jp4_tile_deblock_reorder_core.sv
